/* src/assert_macros.svh */
// Assertion helpers shared by the LCD interface RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* src/lcd4_pkg.sv */
// Shared types, codes and helper functions for the 4-bit character LCD interface.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lcd4_pkg;

  localparam int LCD4_COUNT_WIDTH = 16;
  localparam int LCD4_QUEUE_DEPTH = 2;
  localparam int LCD4_SKIP_STEPS  = 3;

  // Request kinds as they arrive on the input
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_INIT  = 2'd2;

  // Classified operations handed to the sequencer
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_INIT  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_PULSE      = 3'd0;
  localparam logic [2:0] REG_GAP        = 3'd1;
  localparam logic [2:0] REG_SETTLE     = 3'd2;
  localparam logic [2:0] REG_INIT_PULSE = 3'd3;
  localparam logic [2:0] REG_INIT_WAIT  = 3'd4;

  // Sequencer phases
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_HI_PULSE   = 4'd1;
  localparam logic [3:0] PH_GAP        = 4'd2;
  localparam logic [3:0] PH_LO_PULSE   = 4'd3;
  localparam logic [3:0] PH_SETTLE     = 4'd4;
  localparam logic [3:0] PH_INIT_PULSE = 4'd5;
  localparam logic [3:0] PH_INIT_WAIT  = 4'd6;

  localparam logic [3:0] INIT_NIBBLES = 4'd4;
  localparam logic [3:0] INIT_STEPS   = 4'd9;
  localparam logic [3:0] INIT_NIB_THREE = 4'h3;
  localparam logic [3:0] INIT_NIB_TWO   = 4'h2;
  localparam logic [3:0] INIT_LAST_NIB  = 4'd3;

  typedef struct packed {
    logic [15:0] pulse_ticks;
    logic [15:0] gap_ticks;
    logic [15:0] settle_ticks;
    logic [15:0] init_pulse_ticks;
    logic [15:0] init_wait_ticks;
  } lcd4_cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       is_data;
  } lcd4_cmd_t;

  typedef struct packed {
    logic [3:0] bus_nibble;
    logic       enable_line;
    logic       select_line;
    logic       busy_res;
    logic       rejected;
  } lcd4_res_t;

  typedef struct packed {
    logic [3:0] phase;
    logic [7:0] held_byte;
    logic       held_select;
    logic [3:0] init_step;
    logic       in_init;
  } lcd4_seq_t;

  // Command bytes sent after the init nibbles
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    case (idx)
      3'd0:    return 8'h28;
      3'd1:    return 8'h0F;
      3'd2:    return 8'h06;
      3'd3:    return 8'h01;
      3'd4:    return 8'h02;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [3:0] init_nibble(input logic [3:0] step);
    return (step == INIT_LAST_NIB) ? INIT_NIB_TWO : INIT_NIB_THREE;
  endfunction

  // One phase transition at the end of a phase
  function automatic lcd4_seq_t leave_phase(input lcd4_seq_t s);
    lcd4_seq_t n;
    n = s;
    case (s.phase)
      PH_HI_PULSE:   n.phase = PH_GAP;
      PH_GAP:        n.phase = PH_LO_PULSE;
      PH_LO_PULSE:   n.phase = PH_SETTLE;
      PH_SETTLE:     n.phase = s.in_init ? PH_INIT_WAIT : PH_IDLE;
      PH_INIT_PULSE: n.phase = PH_INIT_WAIT;
      PH_INIT_WAIT: begin
        n.init_step = s.init_step + 4'd1;
        if (n.init_step < INIT_NIBBLES) begin
          n.phase = PH_INIT_PULSE;
        end else if (n.init_step < INIT_STEPS) begin
          n.held_byte   = init_cmd(3'(n.init_step - INIT_NIBBLES));
          n.held_select = 1'b0;
          n.phase       = PH_HI_PULSE;
        end else begin
          n.in_init = 1'b0;
          n.phase   = PH_IDLE;
        end
      end
      default:       n.phase = PH_IDLE;
    endcase
    return n;
  endfunction

endpackage

/* src/lcd4_fifo.sv */
// Small register-based FIFO used for the command and result queues.
// Depends on lcd4_pkg for the default depth.
`timescale 1ns / 1ps

module lcd4_fifo import lcd4_pkg::*; #(
  parameter type item_t = logic,
  parameter int  DEPTH  = LCD4_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_data,
  output logic  full,
  input  logic  pop,
  output item_t rd_data,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
  localparam logic [AW-1:0] PTR_LAST   = AW'(DEPTH - 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == COUNT_FULL);
  assign empty   = (count == '0);
  assign do_wr   = push && !full;
  assign do_rd   = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/lcd4_front.sv */
// Front end: accepts requests, classifies them and queues them for the sequencer.
// Depends on lcd4_pkg and lcd4_fifo.
`timescale 1ns / 1ps

module lcd4_front import lcd4_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] kind,
  input  logic [7:0] data_byte,
  input  logic       is_data,
  input  logic       cmd_pop,
  output lcd4_cmd_t  cmd,
  output logic       cmd_valid
);

  lcd4_cmd_t cmd_in;
  logic      cmd_empty;

  always_comb begin
    cmd_in.data_byte = data_byte;
    cmd_in.is_data   = is_data;
    case (kind)
      KIND_TICK:  cmd_in.op = OP_TICK;
      KIND_WRITE: cmd_in.op = OP_WRITE;
      KIND_INIT:  cmd_in.op = OP_INIT;
      default:    cmd_in.op = OP_NONE;
    endcase
  end

  lcd4_fifo #(
    .item_t (lcd4_cmd_t)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (cmd_in),
    .full    (full),
    .pop     (cmd_pop),
    .rd_data (cmd),
    .empty   (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

/* src/lcd4_back.sv */
// Back end: bus sequencer giving the bus state after each command. Retires one
// per cycle when the result queue has room. Needs lcd4_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcd4_back import lcd4_pkg::*; #(
  parameter int COUNT_WIDTH = LCD4_COUNT_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  input  lcd4_cfg_t cfg,
  input  lcd4_cmd_t cmd,
  input  logic      cmd_valid,
  output logic      cmd_pop,
  output logic      res_push,
  output lcd4_res_t res,
  input  logic      res_full
);

  localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  lcd4_seq_t              seq;
  lcd4_seq_t              seq_next;
  logic [COUNT_WIDTH-1:0] tick_count;
  logic [COUNT_WIDTH-1:0] tick_count_next;
  logic [COUNT_WIDTH-1:0] dur_pulse;
  logic [COUNT_WIDTH-1:0] dur_gap;
  logic [COUNT_WIDTH-1:0] dur_settle;
  logic [COUNT_WIDTH-1:0] dur_init_pulse;
  logic [COUNT_WIDTH-1:0] dur_init_wait;
  logic [COUNT_WIDTH-1:0] dur_cur;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic                   busy;
  logic                   rej;

  // Saturate a 16-bit register to the counter range
  function automatic logic [COUNT_WIDTH-1:0] clip(input logic [15:0] v);
    logic [31:0] w;
    w = {16'd0, v};
    return (w > CNT_MAX) ? CNT_MAX[COUNT_WIDTH-1:0] : w[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic zero_dur(input logic [3:0] ph, input lcd4_cfg_t c);
    case (ph)
      PH_GAP:       return (c.gap_ticks == 16'd0);
      PH_SETTLE:    return (c.settle_ticks == 16'd0);
      PH_INIT_WAIT: return (c.init_wait_ticks == 16'd0);
      default:      return 1'b0;
    endcase
  endfunction

  // A pulse register of zero still gives a one-tick strobe
  assign dur_pulse      = clip((cfg.pulse_ticks == 16'd0) ? 16'd1 : cfg.pulse_ticks);
  assign dur_gap        = clip(cfg.gap_ticks);
  assign dur_settle     = clip(cfg.settle_ticks);
  assign dur_init_pulse = clip((cfg.init_pulse_ticks == 16'd0) ? 16'd1 : cfg.init_pulse_ticks);
  assign dur_init_wait  = clip(cfg.init_wait_ticks);

  always_comb begin
    case (seq.phase)
      PH_HI_PULSE, PH_LO_PULSE: dur_cur = dur_pulse;
      PH_GAP:                   dur_cur = dur_gap;
      PH_SETTLE:                dur_cur = dur_settle;
      PH_INIT_PULSE:            dur_cur = dur_init_pulse;
      PH_INIT_WAIT:             dur_cur = dur_init_wait;
      default:                  dur_cur = '0;
    endcase
  end

  assign busy     = (seq.phase != PH_IDLE);
  assign tick_inc = tick_count + COUNT_WIDTH'(1);
  assign cmd_pop  = cmd_valid && !res_full;
  assign res_push = cmd_pop;

  always_comb begin
    logic advance;
    advance         = 1'b0;
    seq_next        = seq;
    tick_count_next = tick_count;
    rej             = 1'b0;
    case (cmd.op)
      OP_TICK: begin
        if (busy) begin
          if (tick_inc >= dur_cur) begin
            seq_next        = leave_phase(seq);
            tick_count_next = '0;
            advance         = 1'b1;
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      OP_WRITE: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          seq_next.held_byte   = cmd.data_byte;
          seq_next.held_select = cmd.is_data;
          seq_next.in_init     = 1'b0;
          seq_next.phase       = PH_HI_PULSE;
          tick_count_next      = '0;
        end
      end
      OP_INIT: begin
        if (busy) begin
          rej = 1'b1;
        end else begin
          seq_next.in_init     = 1'b1;
          seq_next.init_step   = 4'd0;
          seq_next.held_select = 1'b0;
          seq_next.phase       = PH_INIT_PULSE;
          tick_count_next      = '0;
        end
      end
      default: ;
    endcase
    // Phases that last zero ticks pass through in the same cycle
    if (advance) begin
      for (int i = 0; i < LCD4_SKIP_STEPS; i++) begin
        if (seq_next.phase != PH_IDLE && zero_dur(seq_next.phase, cfg)) begin
          seq_next = leave_phase(seq_next);
        end
      end
    end
  end

  // Bus view of the state after this command
  always_comb begin
    res.rejected = rej;
    res.busy_res = (seq_next.phase != PH_IDLE);
    case (seq_next.phase)
      PH_HI_PULSE: begin
        res.bus_nibble  = seq_next.held_byte[7:4];
        res.enable_line = 1'b1;
        res.select_line = seq_next.held_select;
      end
      PH_GAP: begin
        res.bus_nibble  = seq_next.held_byte[7:4];
        res.enable_line = 1'b0;
        res.select_line = seq_next.held_select;
      end
      PH_LO_PULSE: begin
        res.bus_nibble  = seq_next.held_byte[3:0];
        res.enable_line = 1'b1;
        res.select_line = seq_next.held_select;
      end
      PH_INIT_PULSE: begin
        res.bus_nibble  = init_nibble(seq_next.init_step);
        res.enable_line = 1'b1;
        res.select_line = 1'b0;
      end
      PH_INIT_WAIT: begin
        res.bus_nibble  = (seq_next.init_step < INIT_NIBBLES) ?
                          init_nibble(seq_next.init_step) : seq_next.held_byte[3:0];
        res.enable_line = 1'b0;
        res.select_line = 1'b0;
      end
      default: begin
        res.bus_nibble  = seq_next.held_byte[3:0];
        res.enable_line = 1'b0;
        res.select_line = seq_next.held_select;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq.phase       <= PH_IDLE;
      seq.held_byte   <= 8'd0;
      seq.held_select <= 1'b0;
      seq.init_step   <= 4'd0;
      seq.in_init     <= 1'b0;
      tick_count      <= '0;
    end else if (cmd_pop) begin
      seq        <= seq_next;
      tick_count <= tick_count_next;
    end
  end

  `ASSERT_IMPLIES(a_idle_count_clear, clk, rst, seq.phase == PH_IDLE, tick_count == '0)
  `ASSERT_IMPLIES(a_init_phase_flag, clk, rst,
                  seq.phase == PH_INIT_PULSE || seq.phase == PH_INIT_WAIT, seq.in_init)
  `ASSERT_IMPLIES(a_reject_only_busy, clk, rst, res_push && res.rejected, busy)
  `ASSERT_ALWAYS(a_count_in_phase, clk, rst, !busy || tick_count < dur_cur)

endmodule

/* src/char_lcd_4bit_interface_core.sv */
// Top level of the 4-bit character LCD interface: config registers, front end,
// sequencer and result queue. Depends on lcd4_pkg, lcd4_fifo, lcd4_front, lcd4_back.
`timescale 1ns / 1ps

// Drives an HD44780-style character LCD over a 4-bit bus. Every input item is
// a time tick, a byte write (command or character data) or an init request,
// and every item yields exactly one result: the bus nibble, enable and register
// select levels after the item, a busy flag, and a rejected flag that is set
// when a write or init arrived while a transfer was still running (the request
// is then dropped). A byte goes out high nibble first, each nibble with an
// enable pulse and a gap in between, then a settle wait; init sends nibbles 3,3,3,2 with
// long pulses and waits, then commands 0x28, 0x0F, 0x06, 0x01, 0x02. All timing
// is counted in tick items, using the five tick registers on the config port
// (index 0 pulse, 1 gap, 2 settle, 3 init pulse, 4 init wait; other indexes
// are ignored); write them only while the block is idle. Throughput is one
// item per clock while the result queue is not full: the sequencer retires one
// queued command every cycle unless it stalls on a full result queue. An item
// passes through the command queue and then the result queue. Both queues are
// two deep, so a stalled consumer backs up into full after a few items.
module char_lcd_4bit_interface_core import lcd4_pkg::*; #(
  parameter int COUNT_WIDTH = LCD4_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic        is_data,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  bus_nibble,
  output logic        enable_line,
  output logic        select_line,
  output logic        busy_res,
  output logic        rejected,
  // configuration writes
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  lcd4_cfg_t cfg;
  lcd4_cmd_t cmd;
  logic      cmd_valid;
  logic      cmd_pop;
  lcd4_res_t res_in;
  lcd4_res_t res_out;
  logic      res_push;
  logic      res_full;

  // Tick registers; writes beyond the last index fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_ticks      <= 16'd2;
      cfg.gap_ticks        <= 16'd2;
      cfg.settle_ticks     <= 16'd50;
      cfg.init_pulse_ticks <= 16'd100;
      cfg.init_wait_ticks  <= 16'd5000;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PULSE:      cfg.pulse_ticks      <= cfg_data;
        REG_GAP:        cfg.gap_ticks        <= cfg_data;
        REG_SETTLE:     cfg.settle_ticks     <= cfg_data;
        REG_INIT_PULSE: cfg.init_pulse_ticks <= cfg_data;
        REG_INIT_WAIT:  cfg.init_wait_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: classify each transfer and queue it
  lcd4_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .data_byte (data_byte),
    .is_data   (is_data),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_valid (cmd_valid)
  );

  // Back: phase/tick sequencer, stalls only when the result queue is full
  lcd4_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  // Result queue decouples the sequencer from the consumer
  lcd4_fifo #(
    .item_t (lcd4_res_t)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign bus_nibble  = res_out.bus_nibble;
  assign enable_line = res_out.enable_line;
  assign select_line = res_out.select_line;
  assign busy_res    = res_out.busy_res;
  assign rejected    = res_out.rejected;

endmodule

/* sim/char_lcd_4bit_interface_core_tb.sv */
// Self-checking testbench for char_lcd_4bit_interface_core: directed and random
// tick/write/init traffic checked against an in-bench model of the LCD sequencer.
// Depends on lcd4_pkg and the RTL under src only.
`timescale 1ns / 1ps

module char_lcd_4bit_interface_core_tb;
  import lcd4_pkg::*;

  // Kind 3 is unused by the block: it must leave the state alone.
  localparam logic [1:0] KIND_SPARE  = 2'd3;
  localparam int         CYCLE_LIMIT = 2000000;
  localparam int         HOLD_CYCLES = 120;
  localparam int         IDLE_PCT    = 30;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  logic [1:0]  kind      = KIND_TICK;
  logic [7:0]  data_byte = 8'h00;
  logic        is_data   = 1'b0;
  logic        pop       = 1'b0;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = REG_PULSE;
  logic [15:0] cfg_data  = 16'h0000;
  logic        full;
  logic        empty;
  logic [3:0]  bus_nibble;
  logic        enable_line;
  logic        select_line;
  logic        busy_res;
  logic        rejected;

  char_lcd_4bit_interface_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .data_byte   (data_byte),
    .is_data     (is_data),
    .empty       (empty),
    .pop         (pop),
    .bus_nibble  (bus_nibble),
    .enable_line (enable_line),
    .select_line (select_line),
    .busy_res    (busy_res),
    .rejected    (rejected),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer model: own copy of the tick registers and the phase state.
  // ---------------------------------------------------------------------------
  logic [15:0] tk_pulse      = 16'd2;
  logic [15:0] tk_gap        = 16'd2;
  logic [15:0] tk_settle     = 16'd50;
  logic [15:0] tk_init_pulse = 16'd100;
  logic [15:0] tk_init_wait  = 16'd5000;

  logic [3:0]  seq_phase  = PH_IDLE;
  logic [15:0] seq_ticks  = 16'd0;
  logic [7:0]  seq_byte   = 8'h00;
  logic        seq_sel    = 1'b0;
  logic [3:0]  seq_step   = 4'd0;
  logic        seq_init   = 1'b0;

  // Commands that follow the four init nibbles.
  logic [7:0] init_cmd_bytes [5] = '{8'h28, 8'h0F, 8'h06, 8'h01, 8'h02};

  // Expected bus levels, oldest first; one entry per accepted item.
  lcd4_res_t lcd_levels_q [$];

  int errors      = 0;
  int cycle_count = 0;
  int hold_req    = 0;   // bumped by a test to make the receiver hold off
  bit steady      = 1'b0; // no random idling on either side while set

  // Length of a phase in ticks; a pulse register of zero acts as one.
  function automatic logic [15:0] phase_ticks(input logic [3:0] ph);
    case (ph)
      PH_HI_PULSE, PH_LO_PULSE: return (tk_pulse == 16'd0) ? 16'd1 : tk_pulse;
      PH_GAP:                   return tk_gap;
      PH_SETTLE:                return tk_settle;
      PH_INIT_PULSE:            return (tk_init_pulse == 16'd0) ? 16'd1 : tk_init_pulse;
      PH_INIT_WAIT:             return tk_init_wait;
      default:                  return 16'd0;
    endcase
  endfunction

  function automatic void next_phase();
    case (seq_phase)
      PH_HI_PULSE:   seq_phase = PH_GAP;
      PH_GAP:        seq_phase = PH_LO_PULSE;
      PH_LO_PULSE:   seq_phase = PH_SETTLE;
      PH_SETTLE:     seq_phase = seq_init ? PH_INIT_WAIT : PH_IDLE;
      PH_INIT_PULSE: seq_phase = PH_INIT_WAIT;
      PH_INIT_WAIT: begin
        seq_step = seq_step + 4'd1;
        if (seq_step < INIT_NIBBLES) begin
          seq_phase = PH_INIT_PULSE;
        end else if (seq_step < INIT_STEPS) begin
          seq_byte  = init_cmd_bytes[seq_step - INIT_NIBBLES];
          seq_sel   = 1'b0;
          seq_phase = PH_HI_PULSE;
        end else begin
          seq_init  = 1'b0;
          seq_phase = PH_IDLE;
        end
      end
      default:       seq_phase = PH_IDLE;
    endcase
    seq_ticks = 16'd0;
  endfunction

  // Zero-length phases fall straight through.
  function automatic void skip_zero_phases();
    while (seq_phase != PH_IDLE && phase_ticks(seq_phase) == 16'd0) next_phase();
  endfunction

  // Advance the model by one item and return the levels the block must show.
  function automatic lcd4_res_t lcd_step_predict(input logic [1:0] k, input logic [7:0] b,
                                                 input logic d);
    lcd4_res_t r;
    logic [3:0] init_nib;
    r.rejected = 1'b0;
    if (k == KIND_TICK) begin
      if (seq_phase != PH_IDLE) begin
        seq_ticks = seq_ticks + 16'd1;
        if (seq_ticks >= phase_ticks(seq_phase)) begin
          next_phase();
          skip_zero_phases();
        end
      end
    end else if (k == KIND_WRITE || k == KIND_INIT) begin
      if (seq_phase != PH_IDLE) begin
        r.rejected = 1'b1;
      end else if (k == KIND_WRITE) begin
        seq_byte  = b;
        seq_sel   = d;
        seq_init  = 1'b0;
        seq_phase = PH_HI_PULSE;
        seq_ticks = 16'd0;
        skip_zero_phases();
      end else begin
        seq_init  = 1'b1;
        seq_step  = 4'd0;
        seq_sel   = 1'b0;
        seq_phase = PH_INIT_PULSE;
        seq_ticks = 16'd0;
        skip_zero_phases();
      end
    end
    init_nib = (seq_step == INIT_LAST_NIB) ? INIT_NIB_TWO : INIT_NIB_THREE;
    r.enable_line = 1'b0;
    r.select_line = seq_sel;
    case (seq_phase)
      PH_HI_PULSE: begin
        r.bus_nibble  = seq_byte[7:4];
        r.enable_line = 1'b1;
      end
      PH_GAP:        r.bus_nibble = seq_byte[7:4];
      PH_LO_PULSE: begin
        r.bus_nibble  = seq_byte[3:0];
        r.enable_line = 1'b1;
      end
      PH_INIT_PULSE: begin
        r.bus_nibble  = init_nib;
        r.enable_line = 1'b1;
        r.select_line = 1'b0;
      end
      PH_INIT_WAIT: begin
        r.bus_nibble  = (seq_step < INIT_NIBBLES) ? init_nib : seq_byte[3:0];
        r.select_line = 1'b0;
      end
      default:       r.bus_nibble = seq_byte[3:0];
    endcase
    r.busy_res = (seq_phase != PH_IDLE);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. push stays high after a transfer so that back-to-back items
  // need one assignment per step; whoever waits next lowers it first.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] k, input logic [7:0] b, input logic d);
    // each cycle idles with the same odds, so idle cycles stay near IDLE_PCT
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    kind      <= k;
    data_byte <= b;
    is_data   <= d;
    // full as read here is the level before the edge, i.e. what the block saw
    do @(posedge clk); while (full);
    lcd_levels_q.push_back(lcd_step_predict(k, b, d));
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, 8'($urandom), 1'($urandom));
  endtask

  // Tick until the model says the sequencer is back to idle.
  task automatic run_to_idle();
    while (seq_phase != PH_IDLE) send_tick();
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain_results();
    push <= 1'b0;
    while (lcd_levels_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all five tick registers plus the unused indexes; block must be idle.
  task automatic program_timing(input logic [15:0] p, input logic [15:0] g,
                                input logic [15:0] s, input logic [15:0] ip,
                                input logic [15:0] iw);
    logic [15:0] vals [8];
    vals = '{p, g, s, ip, iw, 16'($urandom), 16'($urandom), 16'($urandom)};
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      case (3'(i))
        REG_PULSE:      tk_pulse      = vals[i];
        REG_GAP:        tk_gap        = vals[i];
        REG_SETTLE:     tk_settle     = vals[i];
        REG_INIT_PULSE: tk_init_pulse = vals[i];
        REG_INIT_WAIT:  tk_init_wait  = vals[i];
        default: ;
      endcase
    end
    cfg_write <= 1'b0;
  endtask

  // Quiesce fully, then load a new timing set.
  task automatic retime(input logic [15:0] p, input logic [15:0] g, input logic [15:0] s,
                        input logic [15:0] ip, input logic [15:0] iw);
    run_to_idle();
    drain_results();
    program_timing(p, g, s, ip, iw);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check every transfer out, then pick next cycle's pop.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string fname, input logic [3:0] want, input logic [3:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_side
    lcd4_res_t want;
    int hold_seen;
    int hold_left;
    if (!rst && pop && !empty) begin
      if (lcd_levels_q.size() == 0) begin
        $display("%0t: result with no expectation, expected none actual %h",
                 $time, {bus_nibble, enable_line, select_line, busy_res, rejected});
        errors++;
      end else begin
        want = lcd_levels_q.pop_front();
        check_field("bus_nibble", want.bus_nibble, bus_nibble);
        check_field("enable_line", 4'(want.enable_line), 4'(enable_line));
        check_field("select_line", 4'(want.select_line), 4'(select_line));
        check_field("busy_res", 4'(want.busy_res), 4'(busy_res));
        check_field("rejected", 4'(want.rejected), 4'(rejected));
      end
    end
    // A long hold-off, counted here, lets the queues back up into full.
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (steady) begin
      pop <= 1'b1;
    end else begin
      pop <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("char_lcd_4bit_interface_core_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset timing values: idle levels, then one byte at 2/2/50 ticks.
  task automatic test_reset_defaults();
    send_tick();
    send_item(KIND_SPARE, 8'hFF, 1'b1);
    send_item(KIND_WRITE, 8'h5A, 1'b1);
    run_to_idle();
  endtask

  // Minimal timing: each byte in two ticks, rejects and the unused kind; then one byte at 1/2/1.
  task automatic test_byte_writes();
    retime(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(KIND_WRITE, 8'h00, 1'b0);
    send_item(KIND_WRITE, 8'hFF, 1'b1);   // busy: dropped
    send_item(KIND_SPARE, 8'h12, 1'b0);   // no tick
    run_to_idle();
    send_item(KIND_WRITE, 8'hFF, 1'b1);
    send_item(KIND_INIT, 8'h00, 1'b0);    // busy: dropped
    run_to_idle();
    send_item(KIND_WRITE, 8'hA5, 1'b0);
    run_to_idle();
    retime(16'd1, 16'd2, 16'd1, 16'd1, 16'd1);
    send_item(KIND_WRITE, 8'h3C, 1'b1);
    run_to_idle();
  endtask

  // Full init with all waits zero, rejected requests inside it, a restart, then a slower init.
  task automatic test_init_sequence();
    retime(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(KIND_INIT, 8'hFF, 1'b1);
    send_tick();
    send_item(KIND_WRITE, 8'h77, 1'b1);
    send_item(KIND_INIT, 8'h00, 1'b0);
    run_to_idle();
    send_item(KIND_INIT, 8'h00, 1'b0);
    run_to_idle();
    retime(16'd1, 16'd1, 16'd2, 16'd2, 16'd3);
    send_item(KIND_INIT, 8'h00, 1'b0);
    run_to_idle();
  endtask

  // Long settle: a request late in the settle wait is still dropped.
  task automatic test_long_settle();
    retime(16'd1, 16'd0, 16'd90, 16'd1, 16'd0);
    send_item(KIND_WRITE, 8'($urandom), 1'($urandom));
    repeat (80) send_tick();
    send_item(KIND_WRITE, 8'h81, 1'b1);   // still settling: dropped
    run_to_idle();
  endtask

  // Receiver holds off while the sender keeps pushing, then the sender waits
  // for the whole backlog before moving on.
  task automatic test_backpressure();
    retime(16'd2, 16'd1, 16'd3, 16'd1, 16'd2);
    steady = 1'b1;
    hold_req++;
    send_item(KIND_WRITE, 8'($urandom), 1'($urandom));
    repeat (30) send_tick();
    steady = 1'b0;
    drain_results();
  endtask

  task automatic send_random_item();
    int roll;
    logic [1:0] k;
    roll = $urandom_range(99);
    // Idle: mostly start a transfer. Busy: mostly ticks to walk the phases.
    if (seq_phase == PH_IDLE) begin
      k = (roll < 45) ? KIND_WRITE : (roll < 65) ? KIND_INIT :
          (roll < 95) ? KIND_TICK : KIND_SPARE;
    end else begin
      k = (roll < 88) ? KIND_TICK : (roll < 93) ? KIND_WRITE :
          (roll < 97) ? KIND_INIT : KIND_SPARE;
    end
    send_item(k, 8'($urandom), 1'($urandom));
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 4; ph++) begin
      retime(16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
             16'($urandom_range(0, 6)), 16'($urandom_range(0, 3)),
             16'($urandom_range(0, 4)));
      steady = (ph == 2);
      repeat (125) send_random_item();
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_byte_writes();
    test_init_sequence();
    test_long_settle();
    test_backpressure();
    test_random_traffic();
    run_to_idle();
    drain_results();
    repeat (20) @(posedge clk);
    if (lcd_levels_q.size() != 0) begin
      $display("%0t: results never arrived, expected %0d actual 0",
               $time, lcd_levels_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("char_lcd_4bit_interface_core_tb passed");
    end else begin
      $display("char_lcd_4bit_interface_core_tb failed");
    end
    $finish;
  end

endmodule
